// ===== sv/pcer_pkg.sv =====
// pcer_pkg: shared types, constants and CORDIC tables for the cluster extent reducer.
// No dependencies.
`timescale 1ns / 1ps
package pcer_pkg;

  localparam int GUARD = 8;
  localparam int STEPS = 16;
  localparam int STEP_BITS = 5;
  localparam int ANGLE_FRAC = 13;
  localparam int CW = 42;   // CORDIC vector width
  localparam int AW = 34;   // Q30 angle width, signed
  localparam logic signed [AW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [AW-1:0] PI_Q30 = 34'sd3373259426;
  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  typedef struct packed {
    logic signed [15:0] point_x;
    logic signed [15:0] point_z;
    logic [15:0]        cluster_id;
    logic               last_point;
  } pcer_in_t;

  typedef struct packed {
    logic [15:0]        tag_out;
    logic               near_flag;
    logic [15:0]        nearest_range;
    logic signed [15:0] nearest_azimuth;
    logic signed [15:0] least_azimuth;
    logic signed [15:0] greatest_azimuth;
    logic [16:0]        extent_width;
  } pcer_out_t;

  typedef enum logic [2:0] {
    OP_IDLE, OP_LOAD_VEC, OP_STEP_VEC, OP_FINISH_VEC, OP_LOAD_ROT, OP_STEP_ROT,
    OP_FINISH_ROT, OP_EMIT
  } pcer_op_t;

  typedef struct packed {
    pcer_op_t         op;
    logic             sel_high;  // rotation works on the high-azimuth point
  } pcer_cmd_t;

  typedef struct packed {
    logic             is_last;
  } pcer_sts_t;

  function automatic logic [31:0] atan_q30(input logic [STEP_BITS-1:0] i);
    case (i)
      5'd0: return 32'd843314857;  5'd1: return 32'd497837829;
      5'd2: return 32'd263043837;  5'd3: return 32'd133525159;
      5'd4: return 32'd67021687;   5'd5: return 32'd33543516;
      5'd6: return 32'd16775851;   5'd7: return 32'd8388437;
      5'd8: return 32'd4194283;    5'd9: return 32'd2097149;
      5'd10: return 32'd1048576;   5'd11: return 32'd524288;
      5'd12: return 32'd262144;    5'd13: return 32'd131072;
      5'd14: return 32'd65536;     5'd15: return 32'd32768;
      default: return 32'd0;
    endcase
  endfunction

endpackage

// ===== sv/point_cluster_extent_reducer_core.sv =====
// point_cluster_extent_reducer_core: top level joining sequencer and CORDIC datapath.
// Depends on pcer_pkg, pcer_control, pcer_datapath.
//
// channel | dir | handshake                 | payload
// in      | in  | in_valid / in_ready       | pcer_in_t
// out     | out | out_valid / out_ready     | pcer_out_t
// cfg     | in  | cfg_we                    | cfg_data (max_distance)
//
// A point runs through accept, load, 16 vectoring steps of the shared CORDIC and
// finish; a last point adds two rotations and one emit.
// Reset is synchronous; it clears cluster state and sets max_distance to 2000.
// A waiting result is held in the output register while the next point runs.
`timescale 1ns / 1ps
module point_cluster_extent_reducer_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  pcer_pkg::pcer_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pcer_pkg::pcer_out_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_data
);
  import pcer_pkg::*;

  pcer_cmd_t   cmd;
  pcer_sts_t   sts;
  logic        clear;
  logic [15:0] max_distance;

  always_ff @(posedge clk) begin
    if (rst) max_distance <= 16'd2000;
    else if (cfg_we) max_distance <= cfg_data;
  end

  pcer_control u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd, .clear
  );

  pcer_datapath u_dp (
    .clk, .cmd, .clear, .in_item(in_data), .in_take(in_valid && in_ready),
    .max_distance, .sts, .out_item(out_data)
  );
endmodule

// ===== sv/pcer_datapath.sv =====
// pcer_datapath: shared iterative CORDIC, cluster tracking registers and result register.
// Depends on pcer_pkg.
`timescale 1ns / 1ps
module pcer_datapath (
  input  logic                clk,
  input  pcer_pkg::pcer_cmd_t cmd,
  input  logic                clear,
  input  pcer_pkg::pcer_in_t  in_item,
  input  logic                in_take,
  input  logic [15:0]         max_distance,
  output pcer_pkg::pcer_sts_t sts,
  output pcer_pkg::pcer_out_t out_item
);
  import pcer_pkg::*;

  pcer_in_t              cur;
  logic signed [CW-1:0]  re, im;
  logic signed [AW-1:0]  ang;
  logic [STEP_BITS-1:0]  step;
  logic                  origin;
  logic [15:0]           best_range, low_azimuth_range, high_azimuth_range;
  logic signed [15:0]    best_range_azimuth, low_azimuth, high_azimuth;
  logic signed [CW-1:0]  lat_low;

  logic signed [CW-1:0]  dr, di;
  logic                  dir_pos;
  logic signed [AW-1:0]  atn;
  logic signed [CW-1:0]  z0, x0;
  logic [15:0]           rng;
  logic signed [15:0]    az;
  logic [CW+30:0]        prod;
  logic [AW-1:0]         mag;
  logic signed [AW-1:0]  res0, aext;
  logic [15:0]           r_sel;
  logic signed [15:0]    a_sel;
  logic [55:0]           rprod;
  logic signed [CW-1:0]  d;
  logic [CW-1:0]         wabs;
  logic [CW-1:0]         wr;

  assign sts.is_last = cur.last_point;

  always_comb begin
    dr = im >>> step;
    di = re >>> step;
    atn = AW'(signed'({1'b0, atan_q30(step)}));
    dir_pos = (cmd.op == OP_STEP_VEC) ? (im >= 0) : (ang >= 0);
    z0 = CW'(cur.point_z) <<< GUARD;
    x0 = CW'(cur.point_x) <<< GUARD;
    // vectored magnitude stays below 2^25 for 16-bit coordinates
    prod = (re < 0) ? '0 : (CW+31)'(re[25:0]) * (CW+31)'(KINV_Q30);
    rng = (prod + (73'd1 << (29 + GUARD))) >> (30 + GUARD) > 73'hFFFF ? 16'hFFFF
          : 16'(((prod + (73'd1 << (29 + GUARD))) >> (30 + GUARD)));
    mag = (ang < 0) ? AW'(-ang) : AW'(ang);
    mag = (mag + (AW'(1) << (29 - ANGLE_FRAC))) >> (30 - ANGLE_FRAC);
    az = (ang < 0) ? -16'(mag) : 16'(mag);
    if (origin) begin
      rng = '0;
      az = '0;
    end
    r_sel = cmd.sel_high ? high_azimuth_range : low_azimuth_range;
    a_sel = cmd.sel_high ? high_azimuth : low_azimuth;
    aext = AW'(a_sel) <<< (30 - ANGLE_FRAC);
    res0 = aext > HALF_PI_Q30 ? PI_Q30 - aext
         : (aext < -HALF_PI_Q30 ? -PI_Q30 - aext : aext);
    rprod = (56'(r_sel) << GUARD) * 56'(KINV_Q30) + (56'd1 << 29);
    d = lat_low - im;
    wabs = (d < 0) ? CW'(-d) : CW'(d);
    wr = (wabs + (CW'(1) << (GUARD - 1))) >> GUARD;
  end

  always_ff @(posedge clk) begin
    if (in_take) cur <= in_item;
    if (clear) begin
      best_range <= 16'hFFFF;
      best_range_azimuth <= '0;
      low_azimuth <= 16'sh7FFF;
      low_azimuth_range <= '0;
      high_azimuth <= -16'sh8000;
      high_azimuth_range <= '0;
    end
    unique case (cmd.op)
      OP_LOAD_VEC: begin
        step <= '0;
        origin <= (cur.point_x == 0) && (cur.point_z == 0);
        if (z0 < 0) begin
          if (x0 >= 0) begin
            re <= x0; im <= -z0; ang <= HALF_PI_Q30;
          end else begin
            re <= -x0; im <= z0; ang <= -HALF_PI_Q30;
          end
        end else begin
          re <= z0; im <= x0; ang <= '0;
        end
      end
      OP_STEP_VEC, OP_STEP_ROT: begin
        step <= step + 1'b1;
        if (dir_pos == (cmd.op == OP_STEP_VEC)) begin
          re <= re + dr; im <= im - di;
        end else begin
          re <= re - dr; im <= im + di;
        end
        if (dir_pos) ang <= ang + ((cmd.op == OP_STEP_VEC) ? atn : -atn);
        else ang <= ang - ((cmd.op == OP_STEP_VEC) ? atn : -atn);
      end
      OP_FINISH_VEC: begin
        if (rng < best_range) begin
          best_range <= rng; best_range_azimuth <= az;
        end
        if (az < low_azimuth) begin
          low_azimuth <= az; low_azimuth_range <= rng;
        end
        if (az > high_azimuth) begin
          high_azimuth <= az; high_azimuth_range <= rng;
        end
      end
      OP_LOAD_ROT: begin
        step <= '0;
        re <= CW'(rprod >> 30);
        im <= '0;
        ang <= res0;
      end
      OP_FINISH_ROT: lat_low <= im;
      OP_EMIT: begin
        out_item.tag_out <= cur.cluster_id;
        out_item.near_flag <= best_range < max_distance;
        out_item.nearest_range <= best_range;
        out_item.nearest_azimuth <= best_range_azimuth;
        out_item.least_azimuth <= low_azimuth;
        out_item.greatest_azimuth <= high_azimuth;
        out_item.extent_width <= (wr > CW'(17'h1FFFF)) ? 17'h1FFFF : 17'(wr);
      end
      default: ;
    endcase
  end
endmodule

// ===== sv/pcer_control.sv =====
// pcer_control: sequencer for vectoring, two rotations and result handoff.
// Depends on pcer_pkg.
`timescale 1ns / 1ps
module pcer_control (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  pcer_pkg::pcer_sts_t sts,
  output pcer_pkg::pcer_cmd_t cmd,
  output logic                clear
);
  import pcer_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_VEC, S_FIN, S_ROT_LOAD, S_ROT, S_ROT_FIN, S_EMIT
  } state_t;

  state_t               state;
  logic [STEP_BITS-1:0] cnt;
  logic                 second;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd.sel_high = second;
    unique case (state)
      S_IDLE:     cmd.op = OP_IDLE;
      S_LOAD:     cmd.op = OP_LOAD_VEC;
      S_VEC:      cmd.op = OP_STEP_VEC;
      S_FIN:      cmd.op = OP_FINISH_VEC;
      S_ROT_LOAD: cmd.op = OP_LOAD_ROT;
      S_ROT:      cmd.op = OP_STEP_ROT;
      S_ROT_FIN:  cmd.op = second ? OP_IDLE : OP_FINISH_ROT;
      S_EMIT:     cmd.op = (out_valid && !out_ready) ? OP_IDLE : OP_EMIT;
      default:    cmd.op = OP_IDLE;
    endcase
    clear = rst || (state == S_EMIT && !(out_valid && !out_ready));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; second <= 1'b0; out_valid <= 1'b0;
    end else begin
      // a new result may replace one taken at this same edge
      if (state == S_EMIT && !(out_valid && !out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: if (in_valid) state <= S_LOAD;
        S_LOAD: begin
          cnt <= '0; state <= S_VEC;
        end
        S_VEC: begin
          cnt <= cnt + 1'b1;
          if (cnt == STEP_BITS'(STEPS - 1)) state <= S_FIN;
        end
        S_FIN: begin
          second <= 1'b0;
          state <= sts.is_last ? S_ROT_LOAD : S_IDLE;
        end
        S_ROT_LOAD: begin
          cnt <= '0; state <= S_ROT;
        end
        S_ROT: begin
          cnt <= cnt + 1'b1;
          if (cnt == STEP_BITS'(STEPS - 1)) state <= S_ROT_FIN;
        end
        S_ROT_FIN: begin
          if (second) state <= S_EMIT;
          else begin
            second <= 1'b1; state <= S_ROT_LOAD;
          end
        end
        S_EMIT: if (!(out_valid && !out_ready)) begin
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE) else $error("ready outside idle");
  a_emit_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && cmd.op == OP_EMIT) |=> out_valid) else $error("emit lost");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    state == S_VEC |-> cnt < STEP_BITS'(STEPS)) else $error("step overrun");
endmodule
